[rtl/core/dht_pkg.sv]
package dht_pkg;

	typedef enum logic [1:0] {
		STAT_STORED = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_ZERO   = 2'd2
	} dht_status_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH1 = 6'b000100,
		ST_HASH2 = 6'b001000,
		ST_HASH3 = 6'b010000,
		ST_PROBE = 6'b100000
	} dht_state_t;

	localparam int unsigned COUNT_MAX = 15;
	localparam int unsigned PSUM_MAX  = 127;

endpackage

[rtl/core/dht_ram.sv]
module dht_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/double_hash_table_insert.sv]
// A zero key gives its result in the cycle after the request and leaves busy low.
// For a nonzero key, the states HASH1, HASH2 and HASH3 compute the hashes, then one slot
// is read from the table memory per cycle, n slots in all (1 to TABLE_SIZE), and the
// next request is taken as the result shows.
// After reset, busy stays high while every slot of the table memory is cleared.
// The result strobe done is high for one cycle per request.
module double_hash_table_insert
	import dht_pkg::*;
#(
	parameter int TABLE_SIZE = 11,
	parameter int KEY_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] key,
	output logic        done,
	output logic [3:0]  slot,
	output logic [3:0]  probes,
	output logic [1:0]  status,
	output logic [3:0]  stored_count,
	output logic [6:0]  probe_total
);

	localparam int KW   = (KEY_BITS < 16) ? KEY_BITS : 16;
	localparam int XW   = KW + 3;
	localparam int SH   = XW + 10;
	localparam int PW   = $clog2(TABLE_SIZE);
	localparam int NW   = $clog2(TABLE_SIZE + 1);
	localparam int CW   = ((XW > PW) ? XW : PW) + 1;
	localparam int SUMW = ((NW > 7) ? NW : 7) + 1;
	localparam logic [SH-1:0] RCP_N = SH'((64'd1 << SH) / TABLE_SIZE);
	localparam logic [SH-1:0] RCP_D = SH'((64'd1 << SH) / (TABLE_SIZE - 1));

	function automatic logic [PW-1:0] adv_pos(input logic [PW-1:0] pos,
		input logic [PW-1:0] step);
		logic [PW:0] sum;
		sum = (PW+1)'(pos) + (PW+1)'(step);
		return (sum >= (PW+1)'(TABLE_SIZE)) ? PW'(sum - (PW+1)'(TABLE_SIZE)) : PW'(sum);
	endfunction

	dht_state_t         state_q;
	logic [PW-1:0]      clr_q;
	logic               done_q;
	logic [3:0]         key_count_q;
	logic [6:0]         psum_q;
	logic [3:0]         slot_q;
	logic [3:0]         probes_q;
	dht_status_t        status_q;

	logic [KW-1:0]      k_q;
	logic [XW-1:0]      x3_s1;
	logic [XW-1:0]      x7_s1;
	logic [XW+SH-1:0]   p3_s2;
	logic [XW+SH-1:0]   p7_s2;
	logic [XW-1:0]      r3_s3;
	logic [XW-1:0]      r7_s3;
	logic [PW-1:0]      step_q;
	logic [PW-1:0]      chk_pos_q;
	logic [PW-1:0]      iss_pos_q;
	logic [NW-1:0]      n_q;

	logic               accept;
	logic               key_zero;
	logic [CW-1:0]      r3_ext;
	logic [CW-1:0]      r7_ext;
	logic [PW-1:0]      home_c;
	logic [PW-1:0]      step_c;
	logic [NW-1:0]      n_new;
	logic [SUMW-1:0]    psum_add;
	logic               slot_empty;
	logic               table_full;

	logic               ram_we;
	logic [PW-1:0]      ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [PW-1:0]      ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	assign accept   = start && (state_q == ST_IDLE);
	assign key_zero = (key[KW-1:0] == '0);

	assign r3_ext = CW'(r3_s3);
	assign r7_ext = CW'(r7_s3);
	assign home_c = (r3_ext >= CW'(TABLE_SIZE)) ? PW'(r3_ext - CW'(TABLE_SIZE)) : PW'(r3_ext);
	assign step_c = ((r7_ext >= CW'(TABLE_SIZE - 1)) ? PW'(r7_ext - CW'(TABLE_SIZE - 1))
		: PW'(r7_ext)) + PW'(1);

	assign n_new      = n_q + NW'(1);
	assign psum_add   = SUMW'(psum_q) + SUMW'(n_new);
	assign slot_empty = (ram_rdata == '0);
	assign table_full = (n_new == NW'(TABLE_SIZE));

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_PROBE) && slot_empty);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : chk_pos_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : KEY_BITS'(k_q);
	assign ram_raddr = (state_q == ST_HASH3) ? home_c : iss_pos_q;

	dht_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			done_q      <= 1'b0;
			key_count_q <= '0;
			psum_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (key_zero) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_HASH1;
						end
					end
				end
				ST_HASH1: state_q <= ST_HASH2;
				ST_HASH2: state_q <= ST_HASH3;
				ST_HASH3: state_q <= ST_PROBE;
				ST_PROBE: begin
					if (slot_empty) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (key_count_q != 4'(COUNT_MAX)) begin
							key_count_q <= key_count_q + 4'd1;
						end
						psum_q <= (psum_add > SUMW'(PSUM_MAX)) ? 7'(PSUM_MAX) : 7'(psum_add);
					end else if (table_full) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				k_q   <= key[KW-1:0];
				x3_s1 <= XW'(key[KW-1:0]) * XW'(3);
				x7_s1 <= XW'(key[KW-1:0]) * XW'(7);
				slot_q   <= '0;
				probes_q <= '0;
				status_q <= STAT_ZERO;
			end
			ST_HASH1: begin
				p3_s2 <= (XW+SH)'(x3_s1) * (XW+SH)'(RCP_N);
				p7_s2 <= (XW+SH)'(x7_s1) * (XW+SH)'(RCP_D);
			end
			ST_HASH2: begin
				r3_s3 <= x3_s1 - p3_s2[XW+SH-1:SH] * XW'(TABLE_SIZE);
				r7_s3 <= x7_s1 - p7_s2[XW+SH-1:SH] * XW'(TABLE_SIZE - 1);
			end
			ST_HASH3: begin
				step_q    <= step_c;
				chk_pos_q <= home_c;
				iss_pos_q <= adv_pos(home_c, step_c);
				n_q       <= '0;
			end
			ST_PROBE: begin
				if (slot_empty) begin
					slot_q   <= 4'(chk_pos_q);
					probes_q <= 4'(n_new);
					status_q <= STAT_STORED;
				end else if (table_full) begin
					slot_q   <= '0;
					probes_q <= 4'(n_new);
					status_q <= STAT_FULL;
				end else begin
					chk_pos_q <= iss_pos_q;
					iss_pos_q <= adv_pos(iss_pos_q, step_q);
					n_q       <= n_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign slot         = slot_q;
	assign probes       = probes_q;
	assign status       = status_q;
	assign stored_count = key_count_q;
	assign probe_total  = psum_q;

endmodule

[rtl/core/dht_checker.sv]
module dht_checker
	import dht_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] key,
	input logic        done,
	input logic [3:0]  slot,
	input logic [3:0]  probes,
	input logic [1:0]  status,
	input logic [3:0]  stored_count,
	input logic [6:0]  probe_total
);

	// A zero key is answered in the next cycle with a rejection.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (key == '0) |=> done && (status == STAT_ZERO))
		else $error("zero key request not rejected in the next cycle");

	// A rejected request places nothing and examines nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_ZERO) |-> (slot == '0) && (probes == '0))
		else $error("zero key result carries a slot or probe count");

	// A full table places nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_FULL) |-> (slot == '0))
		else $error("table full result carries a slot");

	// A stored key leaves a nonzero count and probe total.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_STORED) |-> (stored_count != '0) && (probe_total != '0))
		else $error("stored key not reflected in the running totals");

	// The stored count never decreases.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> stored_count >= $past(stored_count))
		else $error("stored count decreased");

endmodule

bind double_hash_table_insert dht_checker u_dht_checker (.*);

[verif/dht_insert_checker.sv]
module dht_insert_checker
	import dht_pkg::*;
#(
	parameter int TABLE_SIZE = 11,
	parameter int KEY_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] key,
	input  logic        done,
	input  logic [3:0]  slot,
	input  logic [3:0]  probes,
	input  logic [1:0]  status,
	input  logic [3:0]  stored_count,
	input  logic [6:0]  probe_total,
	output int          mismatch_count,
	output int          outstanding
);

	typedef struct packed {
		logic [3:0]  slot;
		logic [3:0]  probes;
		dht_status_t status;
		logic [3:0]  count;
		logic [6:0]  total;
	} insert_result_t;

	logic [KEY_BITS-1:0] held_keys [TABLE_SIZE];
	logic [3:0]          key_tally;
	logic [6:0]          probe_tally;
	insert_result_t      awaited_results [$];

	initial begin
		mismatch_count = 0;
		outstanding    = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t dht checker: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Inserts the key into the local copy of the table and returns what the block should report.
	function automatic insert_result_t insert_key(input logic [15:0] raw);
		insert_result_t      res;
		int unsigned         k;
		int unsigned         pos;
		int unsigned         stride;
		int unsigned         n;
		int unsigned         sum;
		bit                  found;
		res   = '0;
		k     = raw & ((32'd1 << KEY_BITS) - 1);
		n     = 0;
		found = 1'b0;
		if (k == 0) begin
			res.status = STAT_ZERO;
		end else begin
			pos    = (k * 3) % TABLE_SIZE;
			stride = ((k * 7) % (TABLE_SIZE - 1)) + 1;
			while (n < TABLE_SIZE && !found) begin
				n++;
				if (held_keys[pos] == '0)
					found = 1'b1;
				else
					pos = (pos + stride) % TABLE_SIZE;
			end
			if (found) begin
				held_keys[pos] = k[KEY_BITS-1:0];
				res.slot = pos[3:0];
				if (key_tally < COUNT_MAX)
					key_tally++;
				sum = probe_tally + n;
				probe_tally = (sum > PSUM_MAX) ? PSUM_MAX[6:0] : sum[6:0];
				res.status = STAT_STORED;
			end else begin
				res.status = STAT_FULL;
			end
		end
		res.probes = n[3:0];
		res.count  = key_tally;
		res.total  = probe_tally;
		return res;
	endfunction

	// Sampling on the falling edge sees the values that the next rising edge will act on.
	always @(negedge clk) begin
		insert_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				held_keys[i] = '0;
			key_tally   = '0;
			probe_tally = '0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no request waiting, slot", slot, 0);
				end else begin
					want = awaited_results.pop_front();
					if (slot !== want.slot)
						report_mismatch("slot", slot, want.slot);
					if (probes !== want.probes)
						report_mismatch("probes", probes, want.probes);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (stored_count !== want.count)
						report_mismatch("stored_count", stored_count, want.count);
					if (probe_total !== want.total)
						report_mismatch("probe_total", probe_total, want.total);
				end
			end
			if (start && !busy)
				awaited_results.push_back(insert_key(key));
		end
		outstanding = awaited_results.size();
	end

endmodule

[verif/tb_double_hash_table_insert.sv]
module tb_double_hash_table_insert;

	localparam int RANDOM_KEYS = 600;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] key;
	logic        done;
	logic [3:0]  slot;
	logic [3:0]  probes;
	logic [1:0]  status;
	logic [3:0]  stored_count;
	logic [6:0]  probe_total;
	int          mismatch_count;
	int          outstanding;
	int          cycle_count;
	bit          burst_mode;

	double_hash_table_insert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.key          (key),
		.done         (done),
		.slot         (slot),
		.probes       (probes),
		.status       (status),
		.stored_count (stored_count),
		.probe_total  (probe_total)
	);

	dht_insert_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.key            (key),
		.done           (done),
		.slot           (slot),
		.probes         (probes),
		.status         (status),
		.stored_count   (stored_count),
		.probe_total    (probe_total),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_double_hash_table_insert: done, errors");
			$finish;
		end
	end

	// Busy only moves on a rising edge, so its value at the falling edge decides acceptance.
	task automatic send_key(input logic [15:0] k);
		int gap;
		bit taken;
		gap = burst_mode ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		key   <= k;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [15:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		unique case (sel)
			0, 1: return 16'h0000;
			2: return 16'h0001 << $urandom_range(0, 15);
			3: return ~(16'h0001 << $urandom_range(0, 15));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic [15:0] directed_keys [] = '{
			16'h0000, 16'h0001, 16'hFFFF, 16'd11, 16'd22, 16'd33, 16'h0001,
			16'h0000, 16'h8000, 16'h5555, 16'hAAAA, 16'h0000, 16'd44, 16'd55,
			16'd66, 16'hFFFF, 16'h0000, 16'h0001
		};
		cycle_count = 0;
		burst_mode  = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		key         = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Home slot zero is crowded on purpose so that later keys probe far, then the table fills.
		foreach (directed_keys[i])
			send_key(directed_keys[i]);

		for (int i = 0; i < RANDOM_KEYS; i++) begin
			if (i % 64 == 0)
				burst_mode = $urandom_range(0, 2) == 0;
			if (i == RANDOM_KEYS / 2 || $urandom_range(0, 49) == 0)
				wait_drained();
			send_key(pick_key());
		end

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("tb_double_hash_table_insert: done, clean");
		else
			$display("tb_double_hash_table_insert: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/core/dht_pkg.sv
rtl/core/dht_ram.sv
rtl/core/double_hash_table_insert.sv
rtl/core/dht_checker.sv
verif/dht_insert_checker.sv
verif/tb_double_hash_table_insert.sv
